>>> rtl/core/nconv_pkg.sv
`default_nettype none
package nconv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int DIM_BITS   = 11;
    localparam int BORDER     = 3;
    localparam int COEFF_BITS = 12;
    localparam int KROW_BITS  = 3 * COEFF_BITS;
    localparam int FRAC_BITS  = 4;
    localparam int PIX_BITS   = 8;
    localparam int CELL_BITS  = PIX_BITS + 1;
    localparam int STORE_BITS = 2 * CELL_BITS;
    localparam int TAPS       = 9;
    localparam int TAP_BITS   = 4;
    localparam int PROD_BITS  = PIX_BITS + 1 + COEFF_BITS;
    localparam int ACC_BITS   = 25;
    localparam int KSUM_BITS  = 16;
    localparam int QUO_BITS   = PIX_BITS;
    localparam int ADDR_BITS  = 6;
    localparam int DATA_BITS  = 64;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KERNEL_ROW0  = 3'd2;
    localparam logic [2:0] REG_KERNEL_ROW1  = 3'd3;
    localparam logic [2:0] REG_KERNEL_ROW2  = 3'd4;
    localparam logic [2:0] REG_FRAC_BITS    = 3'd5;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_in;
        logic                drain;
    } pix_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_out;
        logic                frame_end;
    } res_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]  image_width;
        logic [DIM_BITS-1:0]  image_height;
        logic [KROW_BITS-1:0] kernel_row0;
        logic [KROW_BITS-1:0] kernel_row1;
        logic [KROW_BITS-1:0] kernel_row2;
        logic [FRAC_BITS-1:0] coeff_fraction_bits;
    } cfg_t;

    typedef struct packed {
        logic                accept;
        logic                shift;
        logic                mac;
        logic [TAP_BITS-1:0] mac_idx;
        logic                check;
        logic                div_step;
        logic                emit;
    } cmd_t;

    typedef struct packed {
        logic centre_valid;
        logic interior;
        logic need_div;
        logic slot_free;
    } status_t;

endpackage
`default_nettype wire

>>> rtl/core/nconv_ram.sv
`default_nettype none
module nconv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/core/nconv_regs.sv
`default_nettype none
module nconv_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [nconv_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [nconv_pkg::DATA_BITS-1:0]     pwdata,
    output logic      [nconv_pkg::DATA_BITS-1:0]     prdata,
    output logic                                     pready,
    output nconv_pkg::cfg_t                          cfg
);

    nconv_pkg::cfg_t cfg_reg;
    logic [2:0]      index;
    logic            wr;

    assign index  = paddr[nconv_pkg::ADDR_BITS-1:3];
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width         <= nconv_pkg::DIM_BITS'(640);
            cfg_reg.image_height        <= nconv_pkg::DIM_BITS'(480);
            cfg_reg.kernel_row0         <= '0;
            cfg_reg.kernel_row1         <= nconv_pkg::KROW_BITS'(4096);
            cfg_reg.kernel_row2         <= '0;
            cfg_reg.coeff_fraction_bits <= '0;
        end
        else if (wr)
        begin
            unique case (index)
                nconv_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width <= pwdata[nconv_pkg::DIM_BITS-1:0];
                nconv_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= pwdata[nconv_pkg::DIM_BITS-1:0];
                nconv_pkg::REG_KERNEL_ROW0:
                    cfg_reg.kernel_row0 <= pwdata[nconv_pkg::KROW_BITS-1:0];
                nconv_pkg::REG_KERNEL_ROW1:
                    cfg_reg.kernel_row1 <= pwdata[nconv_pkg::KROW_BITS-1:0];
                nconv_pkg::REG_KERNEL_ROW2:
                    cfg_reg.kernel_row2 <= pwdata[nconv_pkg::KROW_BITS-1:0];
                nconv_pkg::REG_FRAC_BITS:
                    cfg_reg.coeff_fraction_bits <= pwdata[nconv_pkg::FRAC_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            nconv_pkg::REG_IMAGE_WIDTH:
                prdata = nconv_pkg::DATA_BITS'(cfg_reg.image_width);
            nconv_pkg::REG_IMAGE_HEIGHT:
                prdata = nconv_pkg::DATA_BITS'(cfg_reg.image_height);
            nconv_pkg::REG_KERNEL_ROW0:
                prdata = nconv_pkg::DATA_BITS'(cfg_reg.kernel_row0);
            nconv_pkg::REG_KERNEL_ROW1:
                prdata = nconv_pkg::DATA_BITS'(cfg_reg.kernel_row1);
            nconv_pkg::REG_KERNEL_ROW2:
                prdata = nconv_pkg::DATA_BITS'(cfg_reg.kernel_row2);
            nconv_pkg::REG_FRAC_BITS:
                prdata = nconv_pkg::DATA_BITS'(cfg_reg.coeff_fraction_bits);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/core/nconv_ctrl.sv
`default_nettype none
module nconv_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pix_valid,
    output logic                    pix_stall,
    input  wire nconv_pkg::status_t status,
    output nconv_pkg::cmd_t         cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [nconv_pkg::TAP_BITS-1:0] LAST_TAP =
        nconv_pkg::TAP_BITS'(nconv_pkg::TAPS - 1);
    localparam logic [nconv_pkg::TAP_BITS-1:0] LAST_DIV =
        nconv_pkg::TAP_BITS'(nconv_pkg::QUO_BITS - 1);

    logic [2:0]                    state_reg, state_next;
    logic [nconv_pkg::TAP_BITS-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.mac_idx  = step_reg;
        pix_stall    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                pix_stall = 1'b0;
                if (pix_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                step_next = '0;
                if (!status.centre_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.interior)
                begin
                    state_next = S_MAC;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_MAC:
            begin
                cmd.mac   = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_TAP)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                step_next  = '0;
                state_next = status.need_div ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_DIV)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold the result until the output slot frees up
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_to_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_SHIFT)
        else $error("accepted item did not move to shift");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !status.slot_free) |=> state_reg == S_EMIT)
        else $error("result left while output slot busy");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg != LAST_DIV) |=> state_reg == S_DIV)
        else $error("division cut short");

    a_mac_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC && step_reg != LAST_TAP) |=> state_reg == S_MAC)
        else $error("accumulation cut short");

endmodule
`default_nettype wire

>>> rtl/core/nconv_dp.sv
`default_nettype none
module nconv_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nconv_pkg::cfg_t    cfg,
    input  wire nconv_pkg::pix_t    pix,
    input  wire nconv_pkg::cmd_t    cmd,
    output nconv_pkg::status_t      status,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output nconv_pkg::res_t         res
);

    localparam int DB = nconv_pkg::DIM_BITS;
    localparam int CB = nconv_pkg::COL_BITS;
    localparam int AB = nconv_pkg::ACC_BITS;
    localparam int KB = nconv_pkg::COEFF_BITS;
    localparam int PB = nconv_pkg::PIX_BITS;
    localparam int VB = nconv_pkg::CELL_BITS;
    localparam int SB = nconv_pkg::KSUM_BITS;

    logic [DB-1:0] w_eff, h_eff;
    logic [CB-1:0] in_col_reg, out_col_reg, col_reg, col_sel;
    logic [DB-1:0] in_row_reg, out_row_reg;
    logic [DB:0]   hwm_reg;
    logic [VB-1:0] item_reg;
    logic [nconv_pkg::TAPS-1:0] win_valid_reg;
    logic [PB-1:0] win_pix_reg [nconv_pkg::TAPS];
    logic          last_reg;
    logic signed [AB-1:0] acc_reg;
    logic signed [SB-1:0] ksum_reg;
    logic [AB-1:0] rem_reg, dsh_reg;
    logic [PB-1:0] result_reg;
    logic          res_valid_reg;
    nconv_pkg::res_t res_reg;

    logic [nconv_pkg::STORE_BITS-1:0] rdata;
    logic [VB-1:0] top, mid;
    logic          hit, top_v, mid_v;
    logic [DB-1:0] col_inc, in_row_inc, out_col_inc, out_row_inc;
    logic          interior, last;

    // effective frame size
    always_comb
    begin
        if (cfg.image_width == '0)
            w_eff = DB'(1);
        else if (cfg.image_width > DB'(nconv_pkg::MAX_WIDTH))
            w_eff = DB'(nconv_pkg::MAX_WIDTH);
        else
            w_eff = cfg.image_width;
        h_eff = (cfg.image_height == '0) ? DB'(1) : cfg.image_height;
    end

    assign col_sel     = (DB'(in_col_reg) < w_eff) ? in_col_reg : '0;
    assign col_inc     = DB'(col_reg) + DB'(1);
    assign in_row_inc  = in_row_reg + DB'(1);
    assign out_col_inc = DB'(out_col_reg) + DB'(1);
    assign out_row_inc = out_row_reg + DB'(1);

    nconv_ram #(
        .WIDTH (nconv_pkg::STORE_BITS),
        .DEPTH (nconv_pkg::MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (col_reg),
        .wdata ({mid_v, mid[PB-1:0], item_reg}),
        .re    (cmd.accept),
        .raddr (col_sel),
        .rdata (rdata)
    );

    // columns below the high-water mark have been written since reset
    assign hit   = (DB+1)'(col_reg) < hwm_reg;
    assign top   = rdata[nconv_pkg::STORE_BITS-1:VB];
    assign mid   = rdata[VB-1:0];
    assign top_v = top[PB] && hit;
    assign mid_v = mid[PB] && hit;

    assign interior = out_row_reg >= DB'(nconv_pkg::BORDER)
                   && DB'(out_col_reg) >= DB'(nconv_pkg::BORDER)
                   && (DB+1)'(out_row_reg) + (DB+1)'(nconv_pkg::BORDER) < (DB+1)'(h_eff)
                   && DB'(out_col_reg) + DB'(nconv_pkg::BORDER) < w_eff;
    assign last = (out_col_inc >= w_eff) && (out_row_inc >= h_eff);

    // coefficient and tap selection
    logic signed [KB-1:0] coeff [nconv_pkg::TAPS];
    logic signed [KB-1:0] k_tap;
    logic [PB-1:0]        p_tap;
    logic signed [nconv_pkg::PROD_BITS-1:0] prod;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            coeff[c]     = cfg.kernel_row0[c*KB +: KB];
            coeff[3 + c] = cfg.kernel_row1[c*KB +: KB];
            coeff[6 + c] = cfg.kernel_row2[c*KB +: KB];
        end
        if (cmd.mac_idx < nconv_pkg::TAP_BITS'(nconv_pkg::TAPS))
        begin
            k_tap = coeff[cmd.mac_idx];
            p_tap = win_pix_reg[cmd.mac_idx];
        end
        else
        begin
            k_tap = '0;
            p_tap = '0;
        end
    end

    assign prod = $signed({1'b0, p_tap}) * k_tap;

    // shortcut results and divider set-up
    logic [AB-1:0] n_mag, d_mag, d_top, shifted;
    logic [PB-1:0] quick_val;
    logic          need_div;

    always_comb
    begin
        n_mag     = acc_reg[AB-1] ? AB'(-acc_reg) : AB'(acc_reg);
        d_mag     = ksum_reg[SB-1] ? AB'(-ksum_reg) : AB'(ksum_reg);
        d_top     = d_mag << PB;
        shifted   = AB'(acc_reg >>> cfg.coeff_fraction_bits);
        quick_val = '0;
        need_div  = 1'b0;
        if (ksum_reg == '0)
        begin
            if (!acc_reg[AB-1] && acc_reg != '0)
                quick_val = (shifted > AB'(255)) ? PB'(255) : shifted[PB-1:0];
        end
        else if (acc_reg == '0 || (acc_reg[AB-1] != ksum_reg[SB-1]))
        begin
            quick_val = '0;
        end
        else if (n_mag >= d_top)
        begin
            quick_val = PB'(255);
        end
        else
        begin
            need_div = 1'b1;
        end
    end

    assign status.centre_valid = win_valid_reg[5];
    assign status.interior     = interior;
    assign status.need_div     = need_div;
    assign status.slot_free    = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            hwm_reg       <= '0;
            win_valid_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.shift)
            begin
                // the centre is emitted as it arrives, so its valid bit drops
                win_valid_reg <= {item_reg[PB], win_valid_reg[8:7], mid_v,
                                  1'b0, win_valid_reg[4], top_v, win_valid_reg[2:1]};
                if (col_inc >= w_eff)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= (in_row_inc >= h_eff) ? '0 : in_row_inc;
                end
                else
                begin
                    in_col_reg <= col_inc[CB-1:0];
                end
                if (col_inc > hwm_reg[DB-1:0] && !hwm_reg[DB])
                    hwm_reg <= {1'b0, col_inc};
                if (win_valid_reg[5])
                begin
                    if (out_col_inc >= w_eff)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= (out_row_inc >= h_eff) ? '0 : out_row_inc;
                    end
                    else
                    begin
                        out_col_reg <= out_col_inc[CB-1:0];
                    end
                end
            end
            if (cmd.emit)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg  <= col_sel;
            item_reg <= pix.drain ? '0 : {1'b1, pix.pixel_in};
        end
        if (cmd.shift)
        begin
            win_pix_reg[0] <= win_pix_reg[1];
            win_pix_reg[1] <= win_pix_reg[2];
            win_pix_reg[2] <= top[PB-1:0];
            win_pix_reg[3] <= win_pix_reg[4];
            win_pix_reg[4] <= win_pix_reg[5];
            win_pix_reg[5] <= mid[PB-1:0];
            win_pix_reg[6] <= win_pix_reg[7];
            win_pix_reg[7] <= win_pix_reg[8];
            win_pix_reg[8] <= item_reg[PB-1:0];
            last_reg       <= last;
            result_reg     <= win_pix_reg[5];
            acc_reg        <= '0;
            ksum_reg       <= '0;
        end
        if (cmd.mac)
        begin
            acc_reg  <= acc_reg + AB'(prod);
            ksum_reg <= ksum_reg + SB'(k_tap);
        end
        if (cmd.check)
        begin
            result_reg <= quick_val;
            rem_reg    <= n_mag;
            dsh_reg    <= d_mag << (PB - 1);
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg    <= rem_reg - dsh_reg;
                result_reg <= {result_reg[PB-2:0], 1'b1};
            end
            else
            begin
                result_reg <= {result_reg[PB-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.emit)
        begin
            res_reg.pixel_out <= result_reg;
            res_reg.frame_end <= last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

>>> rtl/core/normalized_conv3x3_filter_unit.sv
`default_nettype none
// Streaming 3x3 normalized convolution over 8-bit grey frames in raster order.
// Input channel pix (pix_valid/pix_stall): one pixel per item, or a drain item
// that pushes an empty slot through the line stores to flush pending output.
// Output channel res (res_valid/res_stall): one pixel per item with frame_end
// on the last pixel of the frame; output lags the input by image_width+1 slots.
// Pixels at least three rows/columns inside the frame get the kernel sum
// divided by the coefficient sum, clamped to 0..255; others pass through.
// Items are handled one at a time: each gets a line-store read and a shift; a
// border pixel is then loaded into the output, an interior pixel only after
// nine multiply-accumulate steps on a single multiplier, one check and, unless
// a shortcut applies, eight steps of the restoring divider. Frame size and
// kernel are set over the APB port (64-bit data, registers at 8-byte spacing);
// the user must set them only while idle, which the block does not enforce.
// Reset clears counters, window valid bits and the output valid bit; the line
// stores need no clearing. While res_stall is high a result waits in the output
// register; the next item is accepted and processed but its result waits too.
module normalized_conv3x3_filter_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pix_valid,
    output logic                                 pix_stall,
    input  wire nconv_pkg::pix_t                 pix,
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output nconv_pkg::res_t                      res,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nconv_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [nconv_pkg::DATA_BITS-1:0] pwdata,
    output logic      [nconv_pkg::DATA_BITS-1:0] prdata,
    output logic                                 pready
);

    nconv_pkg::cfg_t    cfg;
    nconv_pkg::cmd_t    cmd;
    nconv_pkg::status_t status;

    nconv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nconv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nconv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix       (pix),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
`default_nettype wire
